// ===== hw/rtl/apid_pkg.sv =====
// ---------------------------------------------------------------------------
// apid_pkg
// Shared widths, register codes, reset values and payload types for the
// angle PID controller with conditional integration.
// ---------------------------------------------------------------------------
package apid_pkg;

   localparam int AngleW   = 16;
   localparam int GainW    = 18;
   localparam int LimitW   = 15;
   localparam int IntegW   = 32;
   localparam int DiffW    = AngleW + 1;
   localparam int OutW     = 24;
   localparam int CsrIdxW  = 3;
   localparam int GainFrac = 14;

   localparam int PropW  = GainW + AngleW;
   localparam int IntPW  = GainW + IntegW;
   localparam int DerivW = GainW + DiffW;
   localparam int AccW   = IntPW + 2;
   localparam int ShW    = AccW - GainFrac;

   localparam logic signed [GainW-1:0]  PropGainRst     = GainW'(27034);
   localparam logic signed [GainW-1:0]  IntegGainRst    = GainW'(49);
   localparam logic signed [GainW-1:0]  DerivGainRst    = GainW'(655);
   localparam logic        [LimitW-1:0] ValidLimitRst   = LimitW'(15360);
   localparam logic        [LimitW-1:0] IntegralBandRst = LimitW'(4608);

   typedef enum logic [CsrIdxW-1:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_INTEG_GAIN    = 3'd1,
      REG_DERIV_GAIN    = 3'd2,
      REG_VALID_LIMIT   = 3'd3,
      REG_INTEGRAL_BAND = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [GainW-1:0] prop;
      logic signed [GainW-1:0] integ;
      logic signed [GainW-1:0] deriv;
   } gains_type;

   typedef struct packed {
      logic signed [AngleW-1:0] err;
      logic signed [DiffW-1:0]  diff;
      logic signed [IntegW-1:0] integ;
   } stage_type;

endpackage

// ===== hw/rtl/angle_pid_with_integral_reset_top.sv =====
// registers between item accept and result valid: input, state, product and output stages
// throughput: one item per cycle while rsp_stall is low; stages advance independently and fill bubbles
// the controller state updates as the item leaves the input register
// reset: synchronous, clears valid flags, previous error, integral, and loads
// the default gains, valid limit and integral band
// ---------------------------------------------------------------------------
// angle_pid_with_integral_reset_top
// Angle PID controller with target zero, conditional integral clear and
// saturating Q15.8 correction output.
// ---------------------------------------------------------------------------
module angle_pid_with_integral_reset_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [apid_pkg::AngleW-1:0]   req_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [apid_pkg::OutW-1:0]     rsp_correction,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [apid_pkg::CsrIdxW-1:0]  csr_index,
   input  logic        [apid_pkg::GainW-1:0]    csr_wdata
);

   apid_pkg::gains_type                gains_ff;
   logic        [apid_pkg::LimitW-1:0] valid_limit_ff;
   logic        [apid_pkg::LimitW-1:0] integral_band_ff;

   logic                               in_valid_ff;
   logic signed [apid_pkg::AngleW-1:0] angle_ff;
   logic                               st_valid_ff;
   apid_pkg::stage_type                stage_ff;
   apid_pkg::stage_type                stage_in;
   logic                               prod_valid_ff;
   logic                               rsp_valid_ff;
   logic signed [apid_pkg::OutW-1:0]   rsp_correction_ff;
   logic signed [apid_pkg::OutW-1:0]   correction_in;

   logic rdy_out, rdy_prod, rdy_st, rdy_in;
   logic load_in, load_st, load_prod, load_out;

   always_comb begin
      rdy_out   = !rsp_valid_ff || !rsp_stall;
      rdy_prod  = !prod_valid_ff || rdy_out;
      rdy_st    = !st_valid_ff || rdy_prod;
      rdy_in    = !in_valid_ff || rdy_st;
      load_in   = req_valid && rdy_in;
      load_st   = in_valid_ff && rdy_st;
      load_prod = st_valid_ff && rdy_prod;
      load_out  = prod_valid_ff && rdy_out;
   end

   assign req_stall      = !rdy_in;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_correction = rsp_correction_ff;
   assign csr_ready      = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop    <= apid_pkg::PropGainRst;
         gains_ff.integ   <= apid_pkg::IntegGainRst;
         gains_ff.deriv   <= apid_pkg::DerivGainRst;
         valid_limit_ff   <= apid_pkg::ValidLimitRst;
         integral_band_ff <= apid_pkg::IntegralBandRst;
      end else if (csr_valid) begin
         case (apid_pkg::csr_index_type'(csr_index))
            apid_pkg::REG_PROP_GAIN: begin
               gains_ff.prop <= csr_wdata;
            end
            apid_pkg::REG_INTEG_GAIN: begin
               gains_ff.integ <= csr_wdata;
            end
            apid_pkg::REG_DERIV_GAIN: begin
               gains_ff.deriv <= csr_wdata;
            end
            apid_pkg::REG_VALID_LIMIT: begin
               valid_limit_ff <= csr_wdata[apid_pkg::LimitW-1:0];
            end
            apid_pkg::REG_INTEGRAL_BAND: begin
               integral_band_ff <= csr_wdata[apid_pkg::LimitW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         st_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rdy_in) begin
            in_valid_ff <= req_valid;
         end
         if (rdy_st) begin
            st_valid_ff <= in_valid_ff;
         end
         if (rdy_prod) begin
            prod_valid_ff <= st_valid_ff;
         end
         if (rdy_out) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_in) begin
         angle_ff <= req_angle;
      end
      if (load_st) begin
         stage_ff <= stage_in;
      end
      if (load_out) begin
         rsp_correction_ff <= correction_in;
      end
   end

   apid_front u_front (
      .clock         (clock),
      .reset         (reset),
      .load          (load_st),
      .angle         (angle_ff),
      .valid_limit   (valid_limit_ff),
      .integral_band (integral_band_ff),
      .next_stage    (stage_in)
   );

   apid_mac u_mac (
      .clock      (clock),
      .load       (load_prod),
      .gains      (gains_ff),
      .stage      (stage_ff),
      .correction (correction_in)
   );

endmodule

// ===== hw/rtl/apid_front.sv =====
// ---------------------------------------------------------------------------
// apid_front
// Error selection, saturating integral with conditional clear, and the
// controller state (previous error, integral).
// ---------------------------------------------------------------------------
module apid_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic signed [apid_pkg::AngleW-1:0]    angle,
   input  logic        [apid_pkg::LimitW-1:0]    valid_limit,
   input  logic        [apid_pkg::LimitW-1:0]    integral_band,
   output apid_pkg::stage_type                   next_stage
);

   logic signed [apid_pkg::AngleW-1:0] prev_error_ff;
   logic signed [apid_pkg::IntegW-1:0] integral_ff;

   logic signed [apid_pkg::DiffW-1:0]  angle_ext;
   logic signed [apid_pkg::DiffW-1:0]  limit_ext;
   logic                               in_range;
   logic signed [apid_pkg::AngleW-1:0] err;
   logic signed [apid_pkg::DiffW-1:0]  err_ext;
   logic        [apid_pkg::DiffW-1:0]  mag;
   logic signed [apid_pkg::IntegW:0]   sum_wide;
   logic signed [apid_pkg::IntegW-1:0] sum_sat;
   logic                               clear;
   logic signed [apid_pkg::IntegW-1:0] integral_in;

   always_comb begin
      angle_ext = apid_pkg::DiffW'(angle);
      limit_ext = $signed({2'b00, valid_limit});
      in_range  = (angle_ext > -limit_ext) && (angle_ext < limit_ext);
      err       = in_range ? apid_pkg::AngleW'(-angle_ext) : prev_error_ff;
      err_ext   = apid_pkg::DiffW'(err);
      mag       = err[apid_pkg::AngleW-1] ? apid_pkg::DiffW'(-err_ext)
                                          : apid_pkg::DiffW'(err_ext);
      sum_wide  = (apid_pkg::IntegW+1)'(integral_ff) + (apid_pkg::IntegW+1)'(err);
      if (sum_wide[apid_pkg::IntegW] == sum_wide[apid_pkg::IntegW-1]) begin
         sum_sat = sum_wide[apid_pkg::IntegW-1:0];
      end else if (sum_wide[apid_pkg::IntegW]) begin
         sum_sat = {1'b1, {(apid_pkg::IntegW-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(apid_pkg::IntegW-1){1'b1}}};
      end
      clear = (mag >= {2'b00, integral_band}) || (err == '0) || (prev_error_ff == '0) ||
              (err[apid_pkg::AngleW-1] != prev_error_ff[apid_pkg::AngleW-1]);
      integral_in = clear ? '0 : sum_sat;
      next_stage.err   = err;
      next_stage.diff  = err_ext - apid_pkg::DiffW'(prev_error_ff);
      next_stage.integ = integral_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else if (load) begin
         prev_error_ff <= err;
         integral_ff   <= integral_in;
      end
   end

endmodule

// ===== hw/rtl/apid_mac.sv =====
// ---------------------------------------------------------------------------
// apid_mac
// Registered gain products, then sum, round to Q.8 and saturate to Q15.8.
// ---------------------------------------------------------------------------
module apid_mac (
   input  logic                               clock,
   input  logic                               load,
   input  apid_pkg::gains_type                gains,
   input  apid_pkg::stage_type                stage,
   output logic signed [apid_pkg::OutW-1:0]   correction
);

   logic signed [apid_pkg::PropW-1:0]  prop_ff;
   logic signed [apid_pkg::IntPW-1:0]  integ_ff;
   logic signed [apid_pkg::DerivW-1:0] deriv_ff;
   logic signed [apid_pkg::PropW-1:0]  prop_in;
   logic signed [apid_pkg::IntPW-1:0]  integ_in;
   logic signed [apid_pkg::DerivW-1:0] deriv_in;
   logic signed [apid_pkg::AccW-1:0]   acc;
   logic signed [apid_pkg::ShW-1:0]    shifted;

   always_comb begin
      prop_in  = $signed(gains.prop)  * $signed(stage.err);
      integ_in = $signed(gains.integ) * $signed(stage.integ);
      deriv_in = $signed(gains.deriv) * $signed(stage.diff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prop_ff  <= prop_in;
         integ_ff <= integ_in;
         deriv_ff <= deriv_in;
      end
   end

   always_comb begin
      acc = apid_pkg::AccW'(prop_ff) + apid_pkg::AccW'(integ_ff) +
            apid_pkg::AccW'(deriv_ff) +
            apid_pkg::AccW'(1 << (apid_pkg::GainFrac - 1));
      shifted = apid_pkg::ShW'(acc >>> apid_pkg::GainFrac);
      if ((&shifted[apid_pkg::ShW-1:apid_pkg::OutW-1]) ||
          !(|shifted[apid_pkg::ShW-1:apid_pkg::OutW-1])) begin
         correction = shifted[apid_pkg::OutW-1:0];
      end else if (shifted[apid_pkg::ShW-1]) begin
         correction = {1'b1, {(apid_pkg::OutW-1){1'b0}}};
      end else begin
         correction = {1'b0, {(apid_pkg::OutW-1){1'b1}}};
      end
   end

endmodule

// ===== hw/rtl/apid_checker.sv =====
// ---------------------------------------------------------------------------
// apid_checker
// Port-level checks for the angle PID controller, bound to the top level.
// ---------------------------------------------------------------------------
module apid_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [apid_pkg::OutW-1:0]     rsp_correction,
   input logic                                 csr_valid,
   input logic                                 csr_ready
);

   // held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_correction))
      else $error("result changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // an empty or draining output never backs up the input
   a_no_false_stall: assert property (@(posedge clock)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output can move");

   // configuration writes always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write not taken");

endmodule

bind angle_pid_with_integral_reset_top apid_checker u_apid_checker (.*);

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the angle PID controller: directed corner items,
// then randomized phases with bursty sending, patterned result stalls and
// register changes between phases.
// ---------------------------------------------------------------------------
module testbench;

   localparam int CycleLimit    = 2_000_000;
   localparam int HoldOffCycles = 300;
   localparam int DrainCycles   = 8;
   localparam int RandomPhases  = 8;
   localparam int PhaseItems    = 232;

   localparam logic [apid_pkg::GainW-1:0] GainMax = {1'b0, {(apid_pkg::GainW-1){1'b1}}};
   localparam logic [apid_pkg::GainW-1:0] GainMin = {1'b1, {(apid_pkg::GainW-1){1'b0}}};
   localparam logic [apid_pkg::GainW-1:0] LimMax  =
      apid_pkg::GainW'({apid_pkg::LimitW{1'b1}});

   class pid_scoreboard;
      logic signed [apid_pkg::GainW-1:0]  kp, ki, kd;
      logic        [apid_pkg::LimitW-1:0] limit, band;
      logic signed [apid_pkg::AngleW-1:0] last_err;
      logic signed [apid_pkg::IntegW-1:0] integ_sum;
      logic signed [apid_pkg::OutW-1:0]   corrections[$];
      int                                 errors;

      function new();
         kp        = apid_pkg::PropGainRst;
         ki        = apid_pkg::IntegGainRst;
         kd        = apid_pkg::DerivGainRst;
         limit     = apid_pkg::ValidLimitRst;
         band      = apid_pkg::IntegralBandRst;
         last_err  = '0;
         integ_sum = '0;
         errors    = 0;
      endfunction

      function void set_reg(logic [apid_pkg::CsrIdxW-1:0] idx,
                            logic [apid_pkg::GainW-1:0] data);
         case (idx)
            apid_pkg::REG_PROP_GAIN:     kp = data;
            apid_pkg::REG_INTEG_GAIN:    ki = data;
            apid_pkg::REG_DERIV_GAIN:    kd = data;
            apid_pkg::REG_VALID_LIMIT:   limit = data[apid_pkg::LimitW-1:0];
            apid_pkg::REG_INTEGRAL_BAND: band = data[apid_pkg::LimitW-1:0];
            default: ;
         endcase
      endfunction

      function void note_angle(logic signed [apid_pkg::AngleW-1:0] angle);
         longint ang, e, pe, sum, acc, res, mag, lim, imax, omax, p, i, d;
         bit     flip;
         ang  = angle;
         pe   = last_err;
         lim  = limit;
         p    = kp;
         i    = ki;
         d    = kd;
         imax = longint'(32'h7FFF_FFFF);
         omax = (longint'(1) <<< (apid_pkg::OutW - 1)) - 1;
         e    = (ang > -lim && ang < lim) ? -ang : pe;
         sum  = longint'(integ_sum) + e;
         if (sum > imax) sum = imax;
         if (sum < -imax - 1) sum = -imax - 1;
         mag  = (e < 0) ? -e : e;
         flip = (e == 0) || (pe == 0) || ((e < 0) != (pe < 0));
         if (mag >= longint'(band) || flip) sum = 0;
         acc = p * e + i * sum + d * (e - pe);
         res = (acc + (longint'(1) <<< (apid_pkg::GainFrac - 1))) >>> apid_pkg::GainFrac;
         if (res > omax) res = omax;
         if (res < -omax - 1) res = -omax - 1;
         last_err  = e[apid_pkg::AngleW-1:0];
         integ_sum = sum[apid_pkg::IntegW-1:0];
         corrections.push_back(res[apid_pkg::OutW-1:0]);
      endfunction

      function void check_correction(logic signed [apid_pkg::OutW-1:0] got);
         logic signed [apid_pkg::OutW-1:0] want;
         if (corrections.size() == 0) begin
            $error("correction: no item pending, actual %0d", got);
            errors++;
         end else begin
            want = corrections.pop_front();
            if (got !== want) begin
               $error("correction mismatch: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return corrections.size();
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [apid_pkg::AngleW-1:0]   req_angle;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic signed [apid_pkg::OutW-1:0]     rsp_correction;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic        [apid_pkg::CsrIdxW-1:0]  csr_index;
   logic        [apid_pkg::GainW-1:0]    csr_wdata;

   pid_scoreboard sb = new();
   bit            idling;
   bit            hold_request;
   int            burst_left;
   int            cycle_count;
   int            walk;

   angle_pid_with_integral_reset_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_correction (rsp_correction),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_correction(rsp_correction);
   end

   initial begin
      int hold_left;
      int mode;
      int mode_left;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!idling) begin
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic send_angle(input logic signed [apid_pkg::AngleW-1:0] angle);
      int gap;
      gap = 0;
      if (idling) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 7);
         end
         burst_left--;
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_angle <= angle;
      do @(posedge clock); while (req_stall);
      sb.note_angle(angle);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [apid_pkg::CsrIdxW-1:0] idx,
                            input logic [apid_pkg::GainW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [apid_pkg::GainW-1:0] kp,
                                input logic [apid_pkg::GainW-1:0] ki,
                                input logic [apid_pkg::GainW-1:0] kd,
                                input logic [apid_pkg::GainW-1:0] lim,
                                input logic [apid_pkg::GainW-1:0] band);
      write_reg(apid_pkg::REG_PROP_GAIN, kp);
      write_reg(apid_pkg::REG_INTEG_GAIN, ki);
      write_reg(apid_pkg::REG_DERIV_GAIN, kd);
      write_reg(apid_pkg::REG_VALID_LIMIT, lim);
      write_reg(apid_pkg::REG_INTEGRAL_BAND, band);
   endtask

   function automatic logic [apid_pkg::GainW-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return GainMax;
         1: return GainMin;
         2: return '0;
         3: return apid_pkg::GainW'($urandom_range(0, (1 << apid_pkg::GainW) - 1));
         default: return apid_pkg::GainW'($urandom_range(0, 65536) - 32768);
      endcase
   endfunction

   function automatic logic signed [apid_pkg::AngleW-1:0] pick_angle();
      int span;
      int lim;
      lim  = sb.limit;
      span = (sb.band > 0 && sb.band < sb.limit) ? int'(sb.band) : lim;
      if (span == 0) span = 256;
      case ($urandom_range(0, 11))
         0: return apid_pkg::AngleW'($urandom);
         1: return apid_pkg::AngleW'(($urandom_range(0, 1) ? lim : -lim) +
                                     $urandom_range(0, 2) - 1);
         2: return '0;
         3: walk = $urandom_range(0, 2 * span) - span;
         default: walk = walk + $urandom_range(0, 64) - 32;
      endcase
      if (walk > 32767) walk = 32767;
      if (walk < -32768) walk = -32768;
      return apid_pkg::AngleW'(walk);
   endfunction

   initial begin
      logic [apid_pkg::CsrIdxW-1:0] spare_idx;
      logic [apid_pkg::GainW-1:0]   lim, band;
      reset = 1'b1;
      req_valid = 1'b0;
      req_angle = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idling = 1'b1;
      hold_request = 1'b0;
      burst_left = 0;
      cycle_count = 0;
      walk = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // default settings: limit edges, band edge, sign flips
      send_angle(16'sd0);
      send_angle(16'sd1);
      send_angle(-16'sd1);
      send_angle(16'sd15359);
      send_angle(-16'sd15359);
      send_angle(16'sd15360);
      send_angle(-16'sd15360);
      send_angle(16'sd32767);
      send_angle(-16'sd32768);
      send_angle(16'sd4608);
      send_angle(-16'sd4607);
      send_angle(-16'sd4607);
      send_angle(-16'sd100);
      send_angle(16'sd100);
      settle();

      load_settings(GainMax, GainMin, GainMax, apid_pkg::GainW'('1), LimMax);
      spare_idx = $urandom_range(apid_pkg::REG_INTEGRAL_BAND + 1,
                                 (1 << apid_pkg::CsrIdxW) - 1);
      write_reg(spare_idx, '0);
      send_angle(-16'sd32768);
      send_angle(-16'sd32767);
      send_angle(16'sd32767);
      send_angle(16'sd32766);
      send_angle(-16'sd32766);
      settle();
      write_reg(apid_pkg::REG_VALID_LIMIT, '0);
      send_angle(16'sd100);
      send_angle(-16'sd100);
      settle();
      write_reg(apid_pkg::REG_VALID_LIMIT, apid_pkg::GainW'(apid_pkg::ValidLimitRst));
      write_reg(apid_pkg::REG_INTEGRAL_BAND, '0);
      send_angle(-16'sd200);
      send_angle(-16'sd300);
      send_angle(16'sd400);
      settle();

      for (int p = 0; p < RandomPhases; p++) begin
         if (p == 0) begin
            load_settings(GainMax, GainMax, GainMax, LimMax, LimMax);
         end else if (p == 1) begin
            load_settings(GainMin, GainMin, GainMin, LimMax, '0);
         end else begin
            case ($urandom_range(0, 4))
               0: lim = '0;
               1: lim = LimMax;
               2: lim = apid_pkg::GainW'(apid_pkg::ValidLimitRst);
               default: lim = apid_pkg::GainW'($urandom_range(0, (1 << apid_pkg::GainW) - 1));
            endcase
            case ($urandom_range(0, 4))
               0: band = '0;
               1: band = LimMax;
               default: band = apid_pkg::GainW'($urandom_range(1, 8000));
            endcase
            load_settings(pick_gain(), pick_gain(), pick_gain(), lim, band);
         end
         if ($urandom_range(0, 1)) begin
            spare_idx = $urandom_range(apid_pkg::REG_INTEGRAL_BAND + 1,
                                       (1 << apid_pkg::CsrIdxW) - 1);
            write_reg(spare_idx, apid_pkg::GainW'($urandom));
         end
         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 3 && n == 20) hold_request = 1'b1;
            if (p == 4 && n == PhaseItems / 2) settle();
            send_angle(pick_angle());
         end
         settle();
      end

      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
